/* sv/cda_pkg.sv */
// shared types, constants and the month length function for the calendar date adder
package cda_pkg;

    // sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DAY  = 4'b0010,
        ST_MON  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned DAYS_W   = 16;
    localparam int unsigned ADD_W    = 10;
    // running day sum before normalization
    localparam int unsigned DSUM_W   = DAYS_W + 1;
    // running month sum after the month offset (12 + 1023)
    localparam int unsigned MSUM_W   = 11;

    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
    localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

    localparam logic [DAY_W-1:0] LEN_28 = 5'd28;
    localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
    localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
    localparam logic [DAY_W-1:0] LEN_31 = 5'd31;

    // days in a month; leap is set when the year is a multiple of four
    function automatic logic [DAY_W-1:0] month_length(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        begin
            len = LEN_31;
            case (month)
                MON_FEB:
                begin
                    len = leap ? LEN_29 : LEN_28;
                end
                MON_APR, MON_JUN, MON_SEP, MON_NOV:
                begin
                    len = LEN_30;
                end
                default:
                begin
                    len = LEN_31;
                end
            endcase
            return len;
        end
    endfunction

endpackage

/* sv/calendar_date_adder_top.sv */
// calendar date adder: adds day, month and year offsets to a date with a stepping sequencer
// sequence: the day loop steps through the M month boundaries crossed by the day sum
//   (one month per cycle, up to about 2155), the month loop through the W twelve-month
//   wraps after the month offset (up to 86), then ST_OUT loads the output register
// the input is ready again only once the result is in the output register, so a new word
//   is not taken while the last is in the loops; ST_OUT waits while a result is still held
// reset: rst_n asynchronous active low, returns the sequencer to idle and drops tvalid
module calendar_date_adder_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], add_days[38:23],
    // add_months[48:39], add_years[58:49], zero[63:59]
    input  logic [cda_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_day[4:0], result_month[8:5], result_year[22:9], zero[23]
    output logic [cda_pkg::OUT_DATA_W-1:0]  m_tdata
);

    cda_pkg::state_t                 state_reg, state_next;
    logic [cda_pkg::DSUM_W-1:0]      day_reg, day_next;
    logic [cda_pkg::MSUM_W-1:0]      month_reg, month_next;
    logic [cda_pkg::YEAR_W-1:0]      year_reg, year_next;
    logic [cda_pkg::ADD_W-1:0]       add_m_reg, add_m_next;
    logic [cda_pkg::ADD_W-1:0]       add_y_reg, add_y_next;
    logic                            out_valid_reg, out_valid_next;
    logic [cda_pkg::OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic [cda_pkg::DAY_W-1:0]       in_day;
    logic [cda_pkg::MONTH_W-1:0]     in_month;
    logic [cda_pkg::MONTH_W-1:0]     in_month_clamped;
    logic [cda_pkg::YEAR_W-1:0]      in_year;
    logic [cda_pkg::DAYS_W-1:0]      in_add_d;
    logic [cda_pkg::DSUM_W-1:0]      cur_len;
    logic                            accept;
    logic                            out_free;

    // input field unpacking
    assign in_day   = s_tdata[4:0];
    assign in_month = s_tdata[8:5];
    assign in_year  = s_tdata[22:9];
    assign in_add_d = s_tdata[38:23];

    // month zero runs as january, above december as december
    always_comb
    begin
        in_month_clamped = in_month;
        if (in_month == '0)
        begin
            in_month_clamped = cda_pkg::MON_JAN;
        end
        else if (in_month > cda_pkg::MON_DEC)
        begin
            in_month_clamped = cda_pkg::MON_DEC;
        end
    end

    assign s_tready = (state_reg == cda_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // length of the current month, widened for the day compare
    assign cur_len = {{(cda_pkg::DSUM_W - cda_pkg::DAY_W){1'b0}},
                      cda_pkg::month_length(month_reg[cda_pkg::MONTH_W-1:0],
                                            year_reg[1:0] == 2'b00)};

    // sequencer: day loop, month wrap loop, then hand-off to the output register
    always_comb
    begin
        state_next     = state_reg;
        day_next       = day_reg;
        month_next     = month_reg;
        year_next      = year_reg;
        add_m_next     = add_m_reg;
        add_y_next     = add_y_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            cda_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    day_next   = {{(cda_pkg::DSUM_W - cda_pkg::DAY_W){1'b0}}, in_day}
                               + {1'b0, in_add_d};
                    month_next = {{(cda_pkg::MSUM_W - cda_pkg::MONTH_W){1'b0}},
                                  in_month_clamped};
                    year_next  = in_year;
                    add_m_next = s_tdata[48:39];
                    add_y_next = s_tdata[58:49];
                    state_next = cda_pkg::ST_DAY;
                end
            end
            cda_pkg::ST_DAY:
            begin
                // one month boundary per cycle
                if (day_reg > cur_len)
                begin
                    day_next = day_reg - cur_len;
                    if (month_reg[cda_pkg::MONTH_W-1:0] == cda_pkg::MON_DEC)
                    begin
                        month_next = {{(cda_pkg::MSUM_W - cda_pkg::MONTH_W){1'b0}},
                                      cda_pkg::MON_JAN};
                        year_next  = year_reg + 1'b1;
                    end
                    else
                    begin
                        month_next = month_reg + 1'b1;
                    end
                end
                else
                begin
                    month_next = month_reg + {1'b0, add_m_reg};
                    state_next = cda_pkg::ST_MON;
                end
            end
            cda_pkg::ST_MON:
            begin
                // one twelve-month wrap per cycle, then the year offset
                if (month_reg > {{(cda_pkg::MSUM_W - cda_pkg::MONTH_W){1'b0}},
                                 cda_pkg::MON_DEC})
                begin
                    month_next = month_reg - {{(cda_pkg::MSUM_W - cda_pkg::MONTH_W){1'b0}},
                                              cda_pkg::MON_DEC};
                    year_next  = year_reg + 1'b1;
                end
                else
                begin
                    year_next  = year_reg + {{(cda_pkg::YEAR_W - cda_pkg::ADD_W){1'b0}},
                                             add_y_reg};
                    state_next = cda_pkg::ST_OUT;
                end
            end
            cda_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, year_reg,
                                      month_reg[cda_pkg::MONTH_W-1:0],
                                      day_reg[cda_pkg::DAY_W-1:0]};
                    state_next     = cda_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cda_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cda_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        day_reg      <= day_next;
        month_reg    <= month_next;
        year_reg     <= year_next;
        add_m_reg    <= add_m_next;
        add_y_reg    <= add_y_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an accepted word always starts the day loop
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == cda_pkg::ST_DAY)
        else $error("accepted word did not start the day loop");

    // the day loop keeps the month inside january..december
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cda_pkg::ST_DAY |->
            month_reg >= 11'd1 && month_reg <= 11'd12)
        else $error("month out of range during day loop");

    // after the day loop the day fits a month
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cda_pkg::ST_MON |-> day_reg <= 17'd31)
        else $error("day not normalized after day loop");

    // the result leaves with a month of one to twelve
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == cda_pkg::ST_OUT |->
            month_reg >= 11'd1 && month_reg <= 11'd12)
        else $error("month not wrapped before output");

endmodule
